FILE: hw/rtl/swtg_pkg.sv
// Shared constants and prescaler helpers for the square-wave tone generator.
package swtg_pkg;

  localparam int unsigned DIVN_W   = 26;  // dividend width: duration_ms * 1000
  localparam int unsigned DIVD_W   = 17;  // divisor width: twice the half-period
  localparam int unsigned DCNT_W   = 5;   // divider step counter
  localparam int unsigned PROD_W   = 24;  // clocks_per_us * half-period
  localparam int unsigned PCNT_W   = 10;  // prescaler counter
  localparam int unsigned PDIV_W   = 11;  // prescaler divide value, up to 1024
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned LOOPS_W  = 16;

  localparam logic [DIVN_W-1:0] HALF_SEC_US = DIVN_W'(500000);
  localparam logic [9:0]        MS_TO_US    = 10'd1000;

  localparam logic [HALF_W-1:0] THR_1024 = 16'd4000;
  localparam logic [HALF_W-1:0] THR_256  = 16'd2000;
  localparam logic [HALF_W-1:0] THR_128  = 16'd1000;
  localparam logic [HALF_W-1:0] THR_64   = 16'd500;
  localparam logic [HALF_W-1:0] THR_32   = 16'd125;

  localparam logic [SEL_W-1:0] SEL_8    = 3'd0;
  localparam logic [SEL_W-1:0] SEL_32   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_64   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_128  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_256  = 3'd4;
  localparam logic [SEL_W-1:0] SEL_1024 = 3'd5;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  function automatic logic [SEL_W-1:0] presc_sel(input logic [HALF_W-1:0] d);
    logic [SEL_W-1:0] s;
    if (d > THR_1024)     s = SEL_1024;
    else if (d > THR_256) s = SEL_256;
    else if (d > THR_128) s = SEL_128;
    else if (d > THR_64)  s = SEL_64;
    else if (d > THR_32)  s = SEL_32;
    else                  s = SEL_8;
    return s;
  endfunction

  function automatic logic [3:0] presc_shift(input logic [SEL_W-1:0] s);
    logic [3:0] r;
    case (s)
      SEL_8:   r = 4'd3;
      SEL_32:  r = 4'd5;
      SEL_64:  r = 4'd6;
      SEL_128: r = 4'd7;
      SEL_256: r = 4'd8;
      default: r = 4'd10;
    endcase
    return r;
  endfunction

  function automatic logic [PDIV_W-1:0] presc_div(input logic [SEL_W-1:0] s);
    logic [PDIV_W-1:0] r;
    case (s)
      SEL_8:   r = 11'd8;
      SEL_32:  r = 11'd32;
      SEL_64:  r = 11'd64;
      SEL_128: r = 11'd128;
      SEL_256: r = 11'd256;
      default: r = 11'd1024;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/square_wave_tone_generator.sv
// Top level: command sequencer, config register and result register.
// Tick transaction: result in the next cycle, one tick per cycle while not stalled.
// Start transaction: one or two 26-step passes of the shared divider, the second
// skipped for a zero half-period, then any tone load; input is stalled meanwhile.
// Ignored starts answer like ticks.
// Reset (async, active low) idles the tone, clears tone pin, sets clocks_per_us to 16.
module square_wave_tone_generator #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] frequency_hz_i,
  input  logic [15:0] duration_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        buzzer_level_o,
  output logic        drive_enable_o,
  output logic        busy_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swtg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [PROD_W-1:0] TMAX = PROD_W'((64'd1 << COUNTER_BITS) - 64'd1);

  logic [2:0]              state_q, state_d;
  logic [7:0]              cpu_q;
  logic [15:0]             dur_q;
  logic [HALF_W-1:0]       half_q;
  logic [LOOPS_W-1:0]      loops_q;
  logic [PROD_W-1:0]       prod_q;
  logic                    ov_q, ov_d;
  logic                    pin_out_q, play_out_q;

  logic                    in_acc, out_free, real_start, cfg_wr;
  logic                    div_go, div_done;
  logic [DIVN_W-1:0]       div_dvd, div_quot;
  logic [DIVD_W-1:0]       div_dsr;
  logic                    tone_tick, tone_load, playing;
  logic                    pin_next, play_next;
  logic [PROD_W-1:0]       shifted;
  logic [COUNTER_BITS-1:0] ticks;
  logic [SEL_W-1:0]        sel;
  logic                    emit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata  = (paddr[2] == 1'b0) ? {24'd0, cpu_q} : 32'd0;

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign real_start = (cmd_i == CMD_START) && (frequency_hz_i != 16'd0) && !playing;
  assign tone_tick  = in_acc && (cmd_i == CMD_TICK);

  assign sel     = presc_sel(half_q);
  assign shifted = prod_q >> presc_shift(sel);
  assign ticks   = (shifted > TMAX) ? COUNTER_BITS'(TMAX) : shifted[COUNTER_BITS-1:0];

  always_comb begin
    state_d   = state_q;
    div_go    = 1'b0;
    div_dvd   = HALF_SEC_US;
    div_dsr   = {1'b0, frequency_hz_i};
    tone_load = 1'b0;
    emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (real_start) begin
            div_go  = 1'b1;
            state_d = S_DIV1;
          end else begin
            emit = 1'b1;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          if (div_quot[HALF_W-1:0] == '0) begin
            state_d = S_EMIT;
          end else begin
            div_go  = 1'b1;
            div_dvd = DIVN_W'(dur_q) * DIVN_W'(MS_TO_US);
            div_dsr = {div_quot[HALF_W-1:0], 1'b0};
            state_d = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          state_d = (div_quot[LOOPS_W-1:0] == '0) ? S_EMIT : S_LOAD;
        end
      end
      S_LOAD: begin
        tone_load = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (emit) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cpu_q   <= 8'd16;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (cfg_wr) begin
        cpu_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pin_out_q  <= pin_next;
      play_out_q <= play_next;
    end
    if (state_q == S_IDLE && in_acc) begin
      dur_q <= duration_ms_i;
    end
    if (state_q == S_DIV1 && div_done) begin
      half_q <= div_quot[HALF_W-1:0];
    end
    if (state_q == S_DIV2 && div_done) begin
      loops_q <= div_quot[LOOPS_W-1:0];
      prod_q  <= PROD_W'(cpu_q) * PROD_W'(half_q);
    end
  end

  swtg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  swtg_tone #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_tone (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tone_tick),
    .load_i         (tone_load),
    .half_ticks_i   (ticks),
    .sel_i          (sel),
    .loops_i        (loops_q),
    .playing_o      (playing),
    .pin_next_o     (pin_next),
    .playing_next_o (play_next)
  );

  assign out_valid_o    = ov_q;
  assign buzzer_level_o = pin_out_q;
  assign drive_enable_o = play_out_q;
  assign busy_res_o     = play_out_q;

endmodule

FILE: hw/rtl/swtg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module swtg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [swtg_pkg::DIVN_W-1:0]   dividend_i,
  input  logic [swtg_pkg::DIVD_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [swtg_pkg::DIVN_W-1:0]   quotient_o
);
  import swtg_pkg::*;

  localparam logic [DCNT_W-1:0] LAST = DCNT_W'(DIVN_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic [DIVN_W-1:0]   qd_q, qd_d;
  logic [DIVD_W-1:0]   rem_q, rem_d;
  logic [DIVD_W-1:0]   dsr_q, dsr_d;
  logic [DIVD_W:0]     rem_sh;
  logic [DIVD_W+1:0]   diff;
  logic                ge;

  assign rem_sh = {rem_q, qd_q[DIVN_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign ge     = ~diff[DIVD_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qd_d   = qd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      qd_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      qd_d  = {qd_q[DIVN_W-2:0], ge};
      rem_d = ge ? diff[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q  <= qd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = qd_q;

endmodule

FILE: hw/rtl/swtg_tone.sv
// Tone timer: prescaler, half-period timer, period counter and pin state.
module swtg_tone #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tick_i,
  input  logic                           load_i,
  input  logic [COUNTER_BITS-1:0]        half_ticks_i,
  input  logic [swtg_pkg::SEL_W-1:0]     sel_i,
  input  logic [swtg_pkg::LOOPS_W-1:0]   loops_i,
  output logic                           playing_o,
  output logic                           pin_next_o,
  output logic                           playing_next_o
);
  import swtg_pkg::*;

  logic [COUNTER_BITS-1:0] half_q, half_d;
  logic [SEL_W-1:0]        sel_q, sel_d;
  logic [PCNT_W-1:0]       pc_q, pc_d;
  logic [COUNTER_BITS-1:0] tc_q, tc_d;
  logic [LOOPS_W-1:0]      per_q, per_d;
  logic                    pin_q, pin_d;
  logic                    play_q, play_d;
  logic [PDIV_W-1:0]       pc_inc;

  assign pc_inc = {1'b0, pc_q} + 1'b1;

  always_comb begin
    half_d = half_q;
    sel_d  = sel_q;
    pc_d   = pc_q;
    tc_d   = tc_q;
    per_d  = per_q;
    pin_d  = pin_q;
    play_d = play_q;
    if (load_i) begin
      half_d = half_ticks_i;
      sel_d  = sel_i;
      pc_d   = '0;
      tc_d   = '0;
      per_d  = loops_i;
      pin_d  = 1'b1;
      play_d = 1'b1;
    end else if (tick_i && play_q) begin
      if (pc_inc >= presc_div(sel_q)) begin
        pc_d = '0;
        tc_d = tc_q + 1'b1;
      end else begin
        pc_d = pc_inc[PCNT_W-1:0];
      end
      if (tc_d >= half_q) begin
        tc_d = '0;
        if (pin_q) begin
          pin_d = 1'b0;
        end else begin
          per_d = per_q - 1'b1;
          if (per_d == '0) begin
            play_d = 1'b0;
            pc_d   = '0;
          end else begin
            pin_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= '0;
      sel_q  <= '0;
      pc_q   <= '0;
      tc_q   <= '0;
      per_q  <= '0;
      pin_q  <= 1'b0;
      play_q <= 1'b0;
    end else begin
      half_q <= half_d;
      sel_q  <= sel_d;
      pc_q   <= pc_d;
      tc_q   <= tc_d;
      per_q  <= per_d;
      pin_q  <= pin_d;
      play_q <= play_d;
    end
  end

  assign playing_o      = play_q;
  assign pin_next_o     = pin_d;
  assign playing_next_o = play_d;

endmodule

FILE: hw/rtl/swtg_checker.sv
// Port-level checker for the tone generator, bound to the top level.
module swtg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic cmd_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic buzzer_level_o,
  input logic drive_enable_o,
  input logic busy_res_o
);
  import swtg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(buzzer_level_o)
      && $stable(drive_enable_o) && $stable(busy_res_o))
    else $error("stalled result changed");

  a_tick_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CMD_TICK) |=> out_valid_o)
    else $error("tick result not presented next cycle");

  a_busy_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (busy_res_o == drive_enable_o))
    else $error("busy and drive enable disagree");

  a_pin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_enable_o |-> !buzzer_level_o)
    else $error("pin high while released");

endmodule

bind square_wave_tone_generator swtg_checker u_swtg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .cmd_i          (cmd_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .buzzer_level_o (buzzer_level_o),
  .drive_enable_o (drive_enable_o),
  .busy_res_o     (busy_res_o)
);

FILE: dv/square_wave_tone_generator_checker.sv
// Checker for the square-wave tone generator: predicts pin state per transaction and compares.
module square_wave_tone_generator_checker #(
  parameter int unsigned COUNTER_BITS = 8,
  parameter logic [2:0]  CPU_REG_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] frequency_hz_i,
  input  logic [15:0] duration_ms_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        buzzer_level_o,
  input  logic        drive_enable_o,
  input  logic        busy_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatch_count_o,
  output int unsigned open_count_o
);
  import swtg_pkg::*;

  localparam int unsigned TICK_MAX = (32'd1 << COUNTER_BITS) - 32'd1;

  typedef struct packed {
    logic buzzer_level;
    logic drive_enable;
    logic busy;
  } pin_state_t;

  pin_state_t              awaited_pins[$];
  logic [7:0]              clocks_per_us;
  logic [COUNTER_BITS-1:0] half_ticks;
  logic [COUNTER_BITS-1:0] timer_cnt;
  logic [SEL_W-1:0]        div_sel;
  logic [10:0]             presc_cnt;
  logic [15:0]             periods_left;
  logic                    pin_high;
  logic                    playing;

  function automatic logic [10:0] divide_by(input logic [SEL_W-1:0] s);
    case (s)
      SEL_8:   return 11'd8;
      SEL_32:  return 11'd32;
      SEL_64:  return 11'd64;
      SEL_128: return 11'd128;
      SEL_256: return 11'd256;
      default: return 11'd1024;
    endcase
  endfunction

  function automatic void begin_tone(input logic [15:0] f, input logic [15:0] dur);
    logic [31:0]      quot;
    logic [15:0]      half_us;
    logic [63:0]      loops_full;
    logic [15:0]      loops;
    logic [SEL_W-1:0] s;
    logic [31:0]      tk;
    if (f == 16'd0 || playing) return;
    quot    = 32'd500000 / 32'(f);
    half_us = quot[15:0];
    if (half_us == 16'd0) return;
    loops_full = (64'(dur) * 64'd1000) / (64'(half_us) * 64'd2);
    loops      = loops_full[15:0];
    if (loops == 16'd0) return;
    if (half_us > THR_1024)     s = SEL_1024;
    else if (half_us > THR_256) s = SEL_256;
    else if (half_us > THR_128) s = SEL_128;
    else if (half_us > THR_64)  s = SEL_64;
    else if (half_us > THR_32)  s = SEL_32;
    else                        s = SEL_8;
    tk = 32'(clocks_per_us) * 32'(half_us) / 32'(divide_by(s));
    if (tk > TICK_MAX) tk = TICK_MAX;
    half_ticks   = tk[COUNTER_BITS-1:0];
    div_sel      = s;
    presc_cnt    = '0;
    timer_cnt    = '0;
    periods_left = loops;
    pin_high     = 1'b1;
    playing      = 1'b1;
  endfunction

  function automatic void advance_tick();
    if (!playing) return;
    presc_cnt = presc_cnt + 11'd1;
    if (presc_cnt >= divide_by(div_sel)) begin
      presc_cnt = '0;
      timer_cnt = timer_cnt + 1'b1;
    end
    if (timer_cnt >= half_ticks) begin
      timer_cnt = '0;
      if (pin_high) begin
        pin_high = 1'b0;
      end else begin
        periods_left = periods_left - 16'd1;
        if (periods_left == 16'd0) begin
          playing   = 1'b0;
          presc_cnt = '0;
        end else begin
          pin_high = 1'b1;
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic e, input logic a);
    if (e !== a) begin
      mismatch_count_o++;
      $display("%0t: %s expected %0b actual %0b", $time, name, e, a);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pin_state_t want;
    if (!rst_ni) begin
      awaited_pins.delete();
      mismatch_count_o = 0;
      clocks_per_us = 8'd16;
      half_ticks    = '0;
      timer_cnt     = '0;
      div_sel       = SEL_8;
      presc_cnt     = '0;
      periods_left  = '0;
      pin_high      = 1'b0;
      playing       = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CPU_REG_ADDR) begin
        clocks_per_us = pwdata[7:0];
      end
      if (in_valid_i && !in_stall_o) begin
        if (cmd_i == CMD_START) begin_tone(frequency_hz_i, duration_ms_i);
        else advance_tick();
        want.buzzer_level = pin_high;
        want.drive_enable = playing;
        want.busy         = playing;
        awaited_pins.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_pins.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected transaction, buzzer %0b drive %0b busy %0b", $time,
                   buzzer_level_o, drive_enable_o, busy_res_o);
        end else begin
          want = awaited_pins.pop_front();
          check_field("buzzer_level", want.buzzer_level, buzzer_level_o);
          check_field("drive_enable", want.drive_enable, drive_enable_o);
          check_field("busy_res", want.busy, busy_res_o);
        end
      end
    end
    open_count_o = awaited_pins.size();
  end

endmodule

FILE: dv/square_wave_tone_generator_test.sv
// Testbench top for the square-wave tone generator: clock, reset, stimulus and verdict.
module square_wave_tone_generator_test;
  import swtg_pkg::*;

  localparam int unsigned COUNTER_BITS = 8;
  localparam logic [2:0]  CPU_REG_ADDR = 3'd0;
  localparam int unsigned PHASE_ITEMS  = 70;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [15:0] frequency_hz_i;
  logic [15:0] duration_ms_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        buzzer_level_o;
  logic        drive_enable_o;
  logic        busy_res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned open_count;
  logic [7:0]  cpu_now = 8'd16;
  logic        no_gaps = 1'b0;

  square_wave_tone_generator #(
    .COUNTER_BITS(COUNTER_BITS)
  ) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .frequency_hz_i, .duration_ms_i,
    .out_valid_o, .out_stall_i, .buzzer_level_o, .drive_enable_o, .busy_res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  square_wave_tone_generator_checker #(
    .COUNTER_BITS(COUNTER_BITS),
    .CPU_REG_ADDR(CPU_REG_ADDR)
  ) tone_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .frequency_hz_i, .duration_ms_i,
    .out_valid_o, .out_stall_i, .buzzer_level_o, .drive_enable_o, .busy_res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count_o(mismatch_count),
    .open_count_o(open_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 6);
    if (out_valid_o && !out_stall_i) results_seen <= results_seen + 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("square_wave_tone_generator_test: errors");
      $finish;
    end
  end

  // exact tick count from start to release, 0 if the start plays nothing
  function automatic longint unsigned tone_len(input logic [15:0] f, input logic [15:0] dur,
                                               input logic [7:0] cpu);
    int unsigned half_us, loops, div, t;
    if (f == 16'd0) return 0;
    half_us = (32'd500000 / 32'(f)) & 32'hFFFF;
    if (half_us == 0) return 0;
    loops = (32'(dur) * 32'd1000 / (32'd2 * half_us)) & 32'hFFFF;
    if (loops == 0) return 0;
    if (half_us > THR_1024)     div = 1024;
    else if (half_us > THR_256) div = 256;
    else if (half_us > THR_128) div = 128;
    else if (half_us > THR_64)  div = 64;
    else if (half_us > THR_32)  div = 32;
    else                        div = 8;
    t = 32'(cpu) * half_us / div;
    if (t > (32'd1 << COUNTER_BITS) - 32'd1) t = (32'd1 << COUNTER_BITS) - 32'd1;
    return 64'(2 * loops) * 64'(t == 0 ? 1 : t * div);
  endfunction

  function automatic bit pick_tone(input longint unsigned budget, output logic [15:0] f,
                                   output logic [15:0] dur);
    longint unsigned len;
    for (int k = 0; k < 40; k++) begin
      case ($urandom_range(0, 3))
        0:       f = 16'($urandom);
        1:       f = 16'($urandom_range(1, 16));
        2:       f = 16'($urandom_range(60, 3000));
        default: f = 16'($urandom_range(60000, 65535));
      endcase
      case ($urandom_range(0, 2))
        0:       dur = 16'($urandom_range(0, 3));
        1:       dur = 16'($urandom_range(0, 120));
        default: dur = 16'($urandom);
      endcase
      len = tone_len(f, dur, cpu_now);
      if (len != 0 && len <= budget) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_item(input logic c, input logic [15:0] f, input logic [15:0] dur);
    if (!no_gaps && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    frequency_hz_i <= f;
    duration_ms_i  <= dur;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic tick_burst(input int unsigned n);
    repeat (n) push_item(CMD_TICK, 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_seen < items_sent);
  endtask

  task automatic write_cpu(input logic [7:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CPU_REG_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cpu_now = v;
  endtask

  // starts mixed in while the tone still plays must be ignored
  task automatic play_tone(input logic [15:0] f, input logic [15:0] dur, input bit noisy);
    longint unsigned len, n;
    len = tone_len(f, dur, cpu_now);
    push_item(CMD_START, f, dur);
    n = len + $urandom_range(0, 4);
    for (longint unsigned i = 0; i < n; i++) begin
      if (noisy && i < len && $urandom_range(0, 99) < 2) begin
        push_item(CMD_START, 16'($urandom), 16'($urandom));
      end
      push_item(CMD_TICK, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(input logic [7:0] cpu);
    int unsigned     first;
    int unsigned     roll;
    logic [15:0]     f;
    logic [15:0]     dur;
    longint unsigned budget;
    write_cpu(cpu);
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        budget = ($urandom_range(0, 7) == 0) ? 300 : 120;
        if (pick_tone(budget, f, dur)) play_tone(f, dur, 1'b1);
        else tick_burst($urandom_range(1, 4));
      end else if (roll < 75) begin
        tick_burst($urandom_range(1, 8));
      end else if (roll < 96) begin
        if ($urandom_range(0, 1) == 0) push_item(CMD_START, 16'd0, 16'($urandom));
        else push_item(CMD_START, 16'($urandom), 16'd0);
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    logic [7:0] phase_cpu [6];
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_TICK;
    frequency_hz_i = 16'd0;
    duration_ms_i  = 16'd0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = CPU_REG_ADDR;
    pwdata         = 32'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of clocks_per_us, period count wraps to a short tone
    push_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
    push_item(CMD_START, 16'd0, 16'hFFFF);
    push_item(CMD_START, 16'hFFFF, 16'd0);
    push_item(CMD_START, 16'd1, 16'd1);
    play_tone(16'd36000, 16'd1704, 1'b1);

    // zero target, truncated half-period and period count
    write_cpu(8'd0);
    play_tone(16'd7, 16'd50, 1'b0);
    play_tone(16'hFFFF, 16'd918, 1'b1);

    phase_cpu = '{8'd1, 8'd0, 8'd2, 8'($urandom_range(3, 254)), 8'd0, 8'd255};
    for (int p = 0; p < 6; p++) begin
      no_gaps = (p == 4);
      run_phase(phase_cpu[p]);
    end
    no_gaps = 1'b0;

    drain();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && open_count == 0) begin
      $display("square_wave_tone_generator_test: clean");
    end else begin
      $display("square_wave_tone_generator_test: errors");
    end
    $finish;
  end

endmodule
